FILE: sv/http_chunked_body_decoder_macros.svh
// Assertion macros shared by the chunked body decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Same-cycle implication, checked on the rising edge of aclk outside reset.
`define HCBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("chunked decoder check failed");

// Next-cycle implication, checked on the rising edge of aclk outside reset.
`define HCBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("chunked decoder check failed");

`endif

FILE: sv/hcbd_pkg.sv
// Types, codes and the hex digit decoder used by the chunked body decoder.
`default_nettype none

package hcbd_pkg;

    localparam int unsigned SIZE_W  = 31;
    localparam int unsigned TOTAL_W = 32;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [2:0] {
        PH_SIZE     = 3'd0,
        PH_SIZE_LF  = 3'd1,
        PH_DATA     = 3'd2,
        PH_DATA_CR  = 3'd3,
        PH_DATA_LF  = 3'd4,
        PH_FINAL_CR = 3'd5,
        PH_FINAL_LF = 3'd6,
        PH_STOPPED  = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decodes one ASCII hex digit; valid is low for any other character.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        r.valid = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r.value = c[3:0] + 4'd9;
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked transfer body decoder.
`default_nettype none

// Decodes a chunked HTTP body presented one byte per input word and emits one
// output word per payload byte, one when the terminating zero chunk and its CRLF
// have been seen, and one on malformed framing; after completion or an error it
// stays silent until a word with body start set. A byte is accepted every cycle
// while the output is empty or being taken; a stalled output holds the input back.
// Each byte passes through the input register and then the result register, with
// all parsing done combinationally in one pass between them.
// The body limit register may only be written while the decoder is idle.
module http_chunked_body_decoder #(
    parameter int unsigned MAX_SIZE_DIGITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [30:0] cfg_wr_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_body_start,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [7:0]       m_data_byte,
    output logic             m_over_limit
);

    localparam int unsigned DCW = $clog2(MAX_SIZE_DIGITS + 1);
    localparam logic [DCW-1:0] DIGIT_MAX = DCW'(MAX_SIZE_DIGITS);
    localparam logic [hcbd_pkg::SIZE_W-1:0] SIZE_SHIFT_MAX = {4'd0, {27{1'b1}}};

    logic [hcbd_pkg::SIZE_W-1:0]  body_limit_reg;

    logic                         in_valid_reg;
    logic [7:0]                   in_byte_reg;
    logic                         in_start_reg;

    hcbd_pkg::phase_t             phase_reg, phase_next;
    logic [hcbd_pkg::SIZE_W-1:0]  remaining_reg, remaining_next;
    logic [DCW-1:0]               digits_reg, digits_next;
    logic [hcbd_pkg::TOTAL_W-1:0] total_reg, total_next;

    logic                         m_valid_reg, m_valid_next;
    hcbd_pkg::kind_t              m_kind_reg, m_kind_next;
    logic [7:0]                   m_byte_reg, m_byte_next;
    logic                         m_over_reg, m_over_next;

    logic                         advance;
    logic                         res_valid;
    hcbd_pkg::kind_t              res_kind;
    logic [7:0]                   res_byte;
    hcbd_pkg::phase_t             cur_phase;
    logic [hcbd_pkg::SIZE_W-1:0]  cur_remaining;
    logic [DCW-1:0]               cur_digits;
    logic [hcbd_pkg::TOTAL_W-1:0] cur_total;
    logic [hcbd_pkg::SIZE_W-1:0]  dec_remaining;
    hcbd_pkg::hex_digit_t         digit;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_data_byte   = m_byte_reg;
    assign m_over_limit  = m_over_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_limit_reg <= '0;
        end else if (cfg_wr_en) begin
            body_limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_in_byte;
            in_start_reg <= s_body_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= hcbd_pkg::PH_SIZE;
            remaining_reg <= '0;
            digits_reg    <= '0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            digits_reg    <= digits_next;
            total_reg     <= total_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg <= m_kind_next;
        m_byte_reg <= m_byte_next;
        m_over_reg <= m_over_next;
    end

    always_comb begin
        cur_phase     = in_start_reg ? hcbd_pkg::PH_SIZE : phase_reg;
        cur_remaining = in_start_reg ? '0 : remaining_reg;
        cur_digits    = in_start_reg ? '0 : digits_reg;
        cur_total     = in_start_reg ? '0 : total_reg;
        digit         = hcbd_pkg::hex_decode(in_byte_reg);
        dec_remaining = (cur_remaining != '0) ? cur_remaining - 1'b1 : cur_remaining;

        phase_next     = cur_phase;
        remaining_next = cur_remaining;
        digits_next    = cur_digits;
        total_next     = cur_total;
        res_valid      = 1'b0;
        res_kind       = hcbd_pkg::KIND_ERROR;
        res_byte       = 8'd0;

        unique case (cur_phase)
            hcbd_pkg::PH_SIZE: begin
                if (in_byte_reg == hcbd_pkg::CHAR_CR) begin
                    if (cur_digits == '0) begin
                        res_valid = 1'b1;
                    end else begin
                        phase_next = hcbd_pkg::PH_SIZE_LF;
                    end
                end else if (!digit.valid || cur_digits >= DIGIT_MAX
                             || cur_remaining > SIZE_SHIFT_MAX) begin
                    res_valid = 1'b1;
                end else begin
                    remaining_next = {cur_remaining[hcbd_pkg::SIZE_W-5:0], digit.value};
                    digits_next    = cur_digits + 1'b1;
                end
            end
            hcbd_pkg::PH_SIZE_LF: begin
                if (in_byte_reg != hcbd_pkg::CHAR_LF) begin
                    res_valid = 1'b1;
                end else if (cur_remaining == '0) begin
                    phase_next = hcbd_pkg::PH_FINAL_CR;
                end else begin
                    phase_next = hcbd_pkg::PH_DATA;
                end
            end
            hcbd_pkg::PH_DATA: begin
                if (cur_total != '1) begin
                    total_next = cur_total + 1'b1;
                end
                remaining_next = dec_remaining;
                if (dec_remaining == '0) begin
                    phase_next = hcbd_pkg::PH_DATA_CR;
                end
                res_valid = 1'b1;
                res_kind  = hcbd_pkg::KIND_DATA;
                res_byte  = in_byte_reg;
            end
            hcbd_pkg::PH_DATA_CR, hcbd_pkg::PH_FINAL_CR: begin
                if (in_byte_reg != hcbd_pkg::CHAR_CR) begin
                    res_valid = 1'b1;
                end else if (cur_phase == hcbd_pkg::PH_DATA_CR) begin
                    phase_next = hcbd_pkg::PH_DATA_LF;
                end else begin
                    phase_next = hcbd_pkg::PH_FINAL_LF;
                end
            end
            hcbd_pkg::PH_DATA_LF: begin
                if (in_byte_reg != hcbd_pkg::CHAR_LF) begin
                    res_valid = 1'b1;
                end else begin
                    phase_next     = hcbd_pkg::PH_SIZE;
                    remaining_next = '0;
                    digits_next    = '0;
                end
            end
            hcbd_pkg::PH_FINAL_LF: begin
                res_valid = 1'b1;
                if (in_byte_reg == hcbd_pkg::CHAR_LF) begin
                    res_kind = hcbd_pkg::KIND_DONE;
                end
            end
            hcbd_pkg::PH_STOPPED: begin
                res_valid = 1'b0;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase

        if (res_valid && res_kind != hcbd_pkg::KIND_DATA) begin
            phase_next = hcbd_pkg::PH_STOPPED;
        end

        if (!advance) begin
            phase_next     = phase_reg;
            remaining_next = remaining_reg;
            digits_next    = digits_reg;
            total_next     = total_reg;
        end

        m_kind_next  = m_kind_reg;
        m_byte_next  = m_byte_reg;
        m_over_next  = m_over_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (advance && res_valid) begin
            m_valid_next = 1'b1;
            m_kind_next  = res_kind;
            m_byte_next  = res_byte;
            m_over_next  = (body_limit_reg != '0) && (total_next > {1'b0, body_limit_reg});
        end
    end

`include "http_chunked_body_decoder_macros.svh"

    `HCBD_ASSERT_NOW(a_take_implies_advance, in_valid_reg && s_ready, advance)
    `HCBD_ASSERT_NOW(a_stopped_silent,
        advance && !in_start_reg && phase_reg == hcbd_pkg::PH_STOPPED, !res_valid)
    `HCBD_ASSERT_NOW(a_data_has_bytes_due, phase_reg == hcbd_pkg::PH_DATA, remaining_reg != '0)
    `HCBD_ASSERT_NOW(a_digit_count_bound, 1'b1, digits_reg <= DIGIT_MAX)
    `HCBD_ASSERT_NEXT(a_non_data_byte_zero,
        advance && res_valid && res_kind != hcbd_pkg::KIND_DATA,
        m_valid && m_data_byte == 8'd0 && phase_reg == hcbd_pkg::PH_STOPPED)

endmodule

`default_nettype wire
